### sv/gh_pkg.sv
// shared types and constants of the gimbal head kinematics pipeline
package gh_pkg;

  localparam int Deg360 = 23592960;
  localparam int Deg180 = 11796480;
  localparam int Deg90 = 5898240;
  localparam logic [34:0] RedOffset = 35'd2170552320;
  localparam int Pivot = 516030;
  localparam int CordicGain = 652032874;
  localparam int CordicSteps = 18;
  localparam int CordicPerStage = 3;
  localparam int CordicStages = CordicSteps / CordicPerStage;
  localparam int AtanDeg [CordicSteps] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };
  localparam int NumStages = 15;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] angle_a;
    logic signed [31:0] angle_b;
    logic signed [31:0] angle_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] count_x;
    logic signed [31:0] count_y;
    logic signed [31:0] count_z;
    logic signed [31:0] count_a;
    logic signed [31:0] count_b;
    logic signed [31:0] count_c;
    logic               saturated;
  } out_t;

  typedef enum logic [2:0] {
    CfgTcpEnable,
    CfgTcpX,
    CfgTcpY,
    CfgTcpZ,
    CfgScaleX,
    CfgScaleY,
    CfgScaleZ,
    CfgScaleRotary
  } cfg_idx_e;

endpackage

### sv/gh_stream_if.sv
// valid/ready stream interfaces for input points and actuator counts
interface gh_in_if
  import gh_pkg::*;
  ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gh_out_if
  import gh_pkg::*;
  ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/gh_angle_cs.sv
// angle reduction, pipelined cordic and quadrant fold for one axis angle
module gh_angle_cs
  import gh_pkg::*;
(
  input  logic               clk_i,
  input  logic [8:0]         en_i,
  input  logic signed [31:0] angle_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic [34:0]        sum0;
  logic [32:0]        red0;
  logic [28:0]        red0_q;
  logic [28:0]        red1;
  logic signed [25:0] rr;
  logic               flip1;
  logic signed [24:0] r1_q;
  logic               flip1_q;

  logic signed [32:0] x_d [CordicStages];
  logic signed [32:0] y_d [CordicStages];
  logic signed [24:0] z_d [CordicStages];
  logic signed [32:0] x_q [CordicStages];
  logic signed [32:0] y_q [CordicStages];
  logic signed [24:0] z_q [CordicStages];
  logic               flip_q [CordicStages];

  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;

  // coarse reduction modulo a full turn
  always_comb begin
    sum0 = {{3{angle_i[31]}}, angle_i} + RedOffset;
    red0 = sum0[32:0];
    for (int k = 8; k >= 4; k--) begin
      if (red0 >= (33'(Deg360) << k)) red0 = red0 - (33'(Deg360) << k);
    end
  end

  // fine reduction and fold into the right half plane
  always_comb begin
    red1 = red0_q;
    for (int k = 3; k >= 0; k--) begin
      if (red1 >= (29'(Deg360) << k)) red1 = red1 - (29'(Deg360) << k);
    end
    rr = $signed({1'b0, red1[24:0]});
    flip1 = 1'b0;
    if (rr > 26'(Deg180)) rr = rr - 26'(Deg360);
    if (rr > 26'(Deg90)) begin
      rr = rr - 26'(Deg180);
      flip1 = 1'b1;
    end else if (rr < -26'(Deg90)) begin
      rr = rr + 26'(Deg180);
      flip1 = 1'b1;
    end
  end

  always_comb begin
    logic signed [32:0] xc;
    logic signed [32:0] yc;
    logic signed [32:0] xn;
    logic signed [24:0] zc;
    int                 i;
    for (int s = 0; s < CordicStages; s++) begin
      if (s == 0) begin
        xc = 33'(CordicGain);
        yc = '0;
        zc = r1_q;
      end else begin
        xc = x_q[s-1];
        yc = y_q[s-1];
        zc = z_q[s-1];
      end
      for (int j = 0; j < CordicPerStage; j++) begin
        i = s * CordicPerStage + j;
        if (zc >= 0) begin
          xn = xc - (yc >>> i);
          yc = yc + (xc >>> i);
          zc = zc - 25'(AtanDeg[i]);
        end else begin
          xn = xc + (yc >>> i);
          yc = yc - (xc >>> i);
          zc = zc + 25'(AtanDeg[i]);
        end
        xc = xn;
      end
      x_d[s] = xc;
      y_d[s] = yc;
      z_d[s] = zc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) red0_q <= red0[28:0];
    if (en_i[1]) begin
      r1_q    <= rr[24:0];
      flip1_q <= flip1;
    end
    for (int s = 0; s < CordicStages; s++) begin
      if (en_i[2+s]) begin
        x_q[s]    <= x_d[s];
        y_q[s]    <= y_d[s];
        z_q[s]    <= z_d[s];
        flip_q[s] <= (s == 0) ? flip1_q : flip_q[(s == 0) ? 0 : s-1];
      end
    end
    if (en_i[8]) begin
      cos_q <= flip_q[CordicStages-1] ? 32'(-x_q[CordicStages-1]) : 32'(x_q[CordicStages-1]);
      sin_q <= flip_q[CordicStages-1] ? 32'(-y_q[CordicStages-1]) : 32'(y_q[CordicStages-1]);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

### sv/gh_rotate.sv
// tool vector rotation by b then c and position compensation
module gh_rotate
  import gh_pkg::*;
(
  input  logic               clk_i,
  input  logic [3:0]         en_i,
  input  logic               tcp_enable_i,
  input  logic signed [31:0] vx_i,
  input  logic signed [31:0] vy_i,
  input  logic signed [32:0] vz_i,
  input  logic signed [31:0] cos_b_i,
  input  logic signed [31:0] sin_b_i,
  input  logic signed [31:0] cos_c_i,
  input  logic signed [31:0] sin_c_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic signed [37:0] cx_o,
  output logic signed [37:0] cy_o,
  output logic signed [37:0] cz_o
);

  function automatic logic signed [37:0] rnd30(input logic signed [69:0] p);
    logic signed [69:0] t;
    t = p + 70'sd536870912;
    return 38'(t >>> 30);
  endfunction

  logic signed [64:0] vx_e, vz_e, cb_e, sb_e;
  logic signed [64:0] p_xc_q, p_zs_q, p_xs_q, p_zc_q;
  logic signed [31:0] cc1_q, sc1_q, cc2_q, sc2_q;
  logic signed [37:0] xb_q, zb_q, zb2_q;
  logic signed [69:0] xb_e, vy_e, cc_e, sc_e;
  logic signed [69:0] q_xc_q, q_ys_q, q_xs_q, q_yc_q;
  logic signed [37:0] xp, yp;
  logic signed [37:0] cx_q, cy_q, cz_q;

  assign vx_e = 65'(vx_i);
  assign vz_e = 65'(vz_i);
  assign cb_e = 65'(cos_b_i);
  assign sb_e = 65'(sin_b_i);

  assign xb_e = 70'(xb_q);
  assign vy_e = 70'(vy_i);
  assign cc_e = 70'(cc2_q);
  assign sc_e = 70'(sc2_q);

  assign xp = rnd30(q_xc_q) - rnd30(q_ys_q);
  assign yp = rnd30(q_xs_q) + rnd30(q_yc_q);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_xc_q <= vx_e * cb_e;
      p_zs_q <= vz_e * sb_e;
      p_xs_q <= vx_e * sb_e;
      p_zc_q <= vz_e * cb_e;
      cc1_q  <= cos_c_i;
      sc1_q  <= sin_c_i;
    end
    if (en_i[1]) begin
      xb_q  <= rnd30(70'(p_xc_q)) - rnd30(70'(p_zs_q));
      zb_q  <= rnd30(70'(p_xs_q)) + rnd30(70'(p_zc_q));
      cc2_q <= cc1_q;
      sc2_q <= sc1_q;
    end
    if (en_i[2]) begin
      q_xc_q <= xb_e * cc_e;
      q_ys_q <= vy_e * sc_e;
      q_xs_q <= xb_e * sc_e;
      q_yc_q <= vy_e * cc_e;
      zb2_q  <= zb_q;
    end
    if (en_i[3]) begin
      if (tcp_enable_i) begin
        cx_q <= 38'(pos_x_i) + xp - 38'(vx_i);
        cy_q <= 38'(pos_y_i) + yp - 38'(vy_i);
        cz_q <= 38'(pos_z_i) + zb2_q - 38'(vz_i);
      end else begin
        cx_q <= 38'(pos_x_i);
        cy_q <= 38'(pos_y_i);
        cz_q <= 38'(pos_z_i);
      end
    end
  end

  assign cx_o = cx_q;
  assign cy_o = cy_q;
  assign cz_o = cz_q;

endmodule

### sv/gh_scale.sv
// scaling of one axis into rounded, saturated actuator counts
module gh_scale
  import gh_pkg::*;
(
  input  logic               clk_i,
  input  logic [1:0]         en_i,
  input  logic signed [37:0] value_i,
  input  logic [31:0]        scale_i,
  output logic signed [31:0] count_o,
  output logic               sat_o
);

  logic [37:0] mag;
  logic [53:0] mag_e;
  logic [53:0] plo_q, phi_q;
  logic        neg_q;
  logic [54:0] b;
  logic [54:0] qs;
  logic [38:0] q;
  logic signed [31:0] count_q;
  logic        sat_q;

  assign mag   = value_i[37] ? 38'(-value_i) : 38'(value_i);
  assign mag_e = 54'(mag);

  assign b  = 55'(plo_q) + 55'(32'h8000_0000);
  assign qs = (55'(phi_q) + (b >> 16)) >> 16;
  assign q  = qs[38:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      plo_q <= mag_e * 54'(scale_i[15:0]);
      phi_q <= mag_e * 54'(scale_i[31:16]);
      neg_q <= value_i[37];
    end
    if (en_i[1]) begin
      if (!neg_q && q > 39'h0_7FFF_FFFF) begin
        count_q <= 32'sh7FFF_FFFF;
        sat_q   <= 1'b1;
      end else if (neg_q && q > 39'h0_8000_0000) begin
        count_q <= 32'sh8000_0000;
        sat_q   <= 1'b1;
      end else begin
        count_q <= neg_q ? (32'sd0 - $signed(q[31:0])) : $signed(q[31:0]);
        sat_q   <= 1'b0;
      end
    end
  end

  assign count_o = count_q;
  assign sat_o   = sat_q;

endmodule

### sv/gimbal_head_forward_kinematics.sv
// top level of the b/c gimbal head forward kinematics pipeline
// pipeline: 15 register stages, from reduction (2), 18-step cordic (6), fold (1),
// rotation (4) and scaling (2)
// throughput: one transaction per cycle; each stage holds its item under back-pressure
// reset: clears all stage valid bits and loads register defaults
module gimbal_head_forward_kinematics
  import gh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gh_in_if.sink       in_i,
  gh_out_if.source    out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic               tcp_enable_q;
  logic signed [31:0] tcp_x_q, tcp_y_q, tcp_z_q;
  logic [31:0]        scale_x_q, scale_y_q, scale_z_q, scale_rotary_q;
  logic signed [32:0] vz;

  logic [NumStages:0]   en;
  logic [NumStages-1:0] v_q;
  in_t                  pipe_q [13];

  logic signed [31:0] cos_b, sin_b, cos_c, sin_c;
  logic signed [37:0] cx, cy, cz;
  logic signed [31:0] cnt [6];
  logic [5:0]         sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcp_enable_q   <= 1'b0;
      tcp_x_q        <= '0;
      tcp_y_q        <= '0;
      tcp_z_q        <= '0;
      scale_x_q      <= 32'd65536;
      scale_y_q      <= 32'd65536;
      scale_z_q      <= 32'd65536;
      scale_rotary_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTcpEnable:   tcp_enable_q   <= cfg_wdata_i[0];
        CfgTcpX:        tcp_x_q        <= $signed(cfg_wdata_i);
        CfgTcpY:        tcp_y_q        <= $signed(cfg_wdata_i);
        CfgTcpZ:        tcp_z_q        <= $signed(cfg_wdata_i);
        CfgScaleX:      scale_x_q      <= cfg_wdata_i;
        CfgScaleY:      scale_y_q      <= cfg_wdata_i;
        CfgScaleZ:      scale_z_q      <= cfg_wdata_i;
        CfgScaleRotary: scale_rotary_q <= cfg_wdata_i;
      endcase
    end
  end

  assign vz = 33'(tcp_z_q) + 33'(Pivot);

  // a stage moves when its slot is empty or the next one moves
  always_comb begin
    en[NumStages] = out_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) pipe_q[0] <= in_i.data;
    for (int k = 1; k < 13; k++) begin
      if (en[k]) pipe_q[k] <= pipe_q[k-1];
    end
  end

  assign in_i.ready = en[0];

  gh_angle_cs u_cs_b (
    .clk_i   (clk_i),
    .en_i    (en[8:0]),
    .angle_i (in_i.data.angle_b),
    .cos_o   (cos_b),
    .sin_o   (sin_b)
  );

  gh_angle_cs u_cs_c (
    .clk_i   (clk_i),
    .en_i    (en[8:0]),
    .angle_i (in_i.data.angle_c),
    .cos_o   (cos_c),
    .sin_o   (sin_c)
  );

  gh_rotate u_rotate (
    .clk_i        (clk_i),
    .en_i         (en[12:9]),
    .tcp_enable_i (tcp_enable_q),
    .vx_i         (tcp_x_q),
    .vy_i         (tcp_y_q),
    .vz_i         (vz),
    .cos_b_i      (cos_b),
    .sin_b_i      (sin_b),
    .cos_c_i      (cos_c),
    .sin_c_i      (sin_c),
    .pos_x_i      (pipe_q[11].pos_x),
    .pos_y_i      (pipe_q[11].pos_y),
    .pos_z_i      (pipe_q[11].pos_z),
    .cx_o         (cx),
    .cy_o         (cy),
    .cz_o         (cz)
  );

  gh_scale u_scale_x (
    .clk_i (clk_i), .en_i (en[14:13]), .value_i (cx),
    .scale_i (scale_x_q), .count_o (cnt[0]), .sat_o (sat[0])
  );

  gh_scale u_scale_y (
    .clk_i (clk_i), .en_i (en[14:13]), .value_i (cy),
    .scale_i (scale_y_q), .count_o (cnt[1]), .sat_o (sat[1])
  );

  gh_scale u_scale_z (
    .clk_i (clk_i), .en_i (en[14:13]), .value_i (cz),
    .scale_i (scale_z_q), .count_o (cnt[2]), .sat_o (sat[2])
  );

  gh_scale u_scale_a (
    .clk_i (clk_i), .en_i (en[14:13]), .value_i (38'(pipe_q[12].angle_a)),
    .scale_i (scale_rotary_q), .count_o (cnt[3]), .sat_o (sat[3])
  );

  gh_scale u_scale_b (
    .clk_i (clk_i), .en_i (en[14:13]), .value_i (38'(pipe_q[12].angle_b)),
    .scale_i (scale_rotary_q), .count_o (cnt[4]), .sat_o (sat[4])
  );

  gh_scale u_scale_c (
    .clk_i (clk_i), .en_i (en[14:13]), .value_i (38'(pipe_q[12].angle_c)),
    .scale_i (scale_rotary_q), .count_o (cnt[5]), .sat_o (sat[5])
  );

  assign out_o.valid          = v_q[NumStages-1];
  assign out_o.data.count_x   = cnt[0];
  assign out_o.data.count_y   = cnt[1];
  assign out_o.data.count_z   = cnt[2];
  assign out_o.data.count_a   = cnt[3];
  assign out_o.data.count_b   = cnt[4];
  assign out_o.data.count_c   = cnt[5];
  assign out_o.data.saturated = |sat;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> in_i.ready)
    else $error("input not ready with empty first stage");

  a_bubble_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !v_q[NumStages-2] |=> !out_o.valid)
    else $error("result repeated after drain");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.saturated |->
      (cnt[0] == 32'sh7FFF_FFFF || cnt[0] == 32'sh8000_0000 ||
       cnt[1] == 32'sh7FFF_FFFF || cnt[1] == 32'sh8000_0000 ||
       cnt[2] == 32'sh7FFF_FFFF || cnt[2] == 32'sh8000_0000 ||
       cnt[3] == 32'sh7FFF_FFFF || cnt[3] == 32'sh8000_0000 ||
       cnt[4] == 32'sh7FFF_FFFF || cnt[4] == 32'sh8000_0000 ||
       cnt[5] == 32'sh7FFF_FFFF || cnt[5] == 32'sh8000_0000))
    else $error("saturation flag without clipped count");

endmodule
